// ===== sv/assert_macros.svh =====
// Assertion macros shared by the estimator RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== sv/tbe_pkg.sv =====
// Shared types and constants of the timestamp bitrate estimator.
// No dependencies; used by the interfaces, controller, datapath and top level.
package tbe_pkg;

  localparam int CommandW   = 2;
  localparam int StampW     = 33;
  localparam int BytesW     = 16;
  localparam int RateW      = 31;
  localparam int SumW       = 32;
  localparam int WindowW    = 8;
  localparam int WindowLeftW = 9;
  localparam int MaxGapW    = 24;
  localparam int CfgIndexW  = 1;
  localparam int CfgDataW   = 24;

  localparam int ScaleW     = 20;
  localparam int ProductW   = SumW + ScaleW;
  localparam int DivSteps   = RateW;
  localparam int DivCountW  = 5;

  localparam logic [ScaleW-1:0]  RateScale       = ScaleW'(90000 * 8);
  localparam logic [RateW-1:0]   RateMax         = '1;
  localparam logic [WindowW-1:0] WindowLenReset  = 8'd20;
  localparam logic [MaxGapW-1:0] MaxGapReset     = 24'd220000;
  localparam int                 HysteresisShift = 6;

  typedef enum logic [CommandW-1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_RESET   = 2'd1,
    CMD_DISCONT = 2'd2
  } command_t;

  typedef enum logic [CfgIndexW-1:0] {
    REG_WINDOW_LENGTH = 1'b0,
    REG_MAX_GAP       = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic capture;
    logic step;
    logic mul;
    logic div_init;
    logic div_step;
    logic compare;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic recompute;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/tbe_ifs.sv =====
// Valid/ready channel interfaces of the estimator: samples, results, register writes.
// Depends on tbe_pkg for field widths.
interface tbe_sample_if;
  logic                          valid;
  logic                          ready;
  logic [tbe_pkg::CommandW-1:0]  command;
  logic [tbe_pkg::StampW-1:0]    stamp;
  logic [tbe_pkg::BytesW-1:0]    byte_count;

  modport source (output valid, command, stamp, byte_count, input ready);
  modport sink   (input valid, command, stamp, byte_count, output ready);
endinterface

interface tbe_result_if;
  logic                       valid;
  logic                       ready;
  logic [tbe_pkg::RateW-1:0]  rate;
  logic                       rate_changed;

  modport source (output valid, rate, rate_changed, input ready);
  modport sink   (input valid, rate, rate_changed, output ready);
endinterface

interface tbe_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tbe_pkg::CfgIndexW-1:0]  index;
  logic [tbe_pkg::CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/tbe_ctrl.sv =====
// Sequencing state machine of the estimator.
// Depends on tbe_pkg (cmd_t, stat_t) and assert_macros.svh.
`include "assert_macros.svh"

module tbe_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tbe_pkg::stat_t stat,
  output tbe_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_MUL,
    S_INIT,
    S_DIV,
    S_CMP,
    S_EMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_STEP;
        S_STEP: state <= stat.recompute ? S_MUL : S_EMIT;
        S_MUL:  state <= S_INIT;
        S_INIT: state <= S_DIV;
        S_DIV:  if (stat.div_done) state <= S_CMP;
        S_CMP:  state <= S_EMIT;
        S_EMIT: if (stat.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.capture  = (state == S_IDLE) && in_valid;
    cmd.step     = (state == S_STEP);
    cmd.mul      = (state == S_MUL);
    cmd.div_init = (state == S_INIT);
    cmd.div_step = (state == S_DIV);
    cmd.compare  = (state == S_CMP);
    cmd.emit     = (state == S_EMIT) && stat.out_free;
  end

  `ASSERT_NEXT(a_accept_step, clk, rst, in_valid && in_ready, state == S_STEP)
  `ASSERT_IMPLIES(a_emit_free, clk, rst, cmd.emit, stat.out_free)
  `ASSERT_IMPLIES(a_one_cmd, clk, rst, 1'b1, $onehot0(cmd))

endmodule

// ===== sv/tbe_dp.sv =====
// Datapath: estimator state, 32x20 product, restoring divider, output register.
// Depends on tbe_pkg and assert_macros.svh; driven by tbe_ctrl.
`include "assert_macros.svh"

module tbe_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  tbe_pkg::cmd_t                   cmd,
  output tbe_pkg::stat_t                  stat,
  input  logic [tbe_pkg::CommandW-1:0]    in_command,
  input  logic [tbe_pkg::StampW-1:0]      in_stamp,
  input  logic [tbe_pkg::BytesW-1:0]      in_byte_count,
  input  logic                            cfg_valid,
  input  logic [tbe_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [tbe_pkg::CfgDataW-1:0]    cfg_data,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [tbe_pkg::RateW-1:0]       out_rate,
  output logic                            out_rate_changed
);

  // configuration
  logic [tbe_pkg::WindowW-1:0]     window_length;
  logic [tbe_pkg::MaxGapW-1:0]     max_gap_ticks;

  // estimator state
  logic [tbe_pkg::StampW-1:0]      last_stamp, last_stamp_next;
  logic [tbe_pkg::SumW-1:0]        pending_bytes, pending_bytes_next;
  logic [tbe_pkg::SumW-1:0]        tick_sum, tick_sum_next;
  logic [tbe_pkg::SumW-1:0]        byte_sum, byte_sum_next;
  logic [tbe_pkg::WindowLeftW-1:0] window_left, window_left_next;
  logic [tbe_pkg::RateW-1:0]       reported_rate, reported_rate_next;
  logic                            changed;

  // captured item
  logic [tbe_pkg::CommandW-1:0]    command_q;
  logic [tbe_pkg::StampW-1:0]      stamp_q;
  logic [tbe_pkg::BytesW-1:0]      bytes_q;

  // division
  logic [tbe_pkg::ProductW-1:0]    product;
  logic [tbe_pkg::SumW-1:0]        divisor_q;
  logic                            sat_q;
  logic [tbe_pkg::SumW-1:0]        rem;
  logic [tbe_pkg::RateW-1:0]       dividend_lo;
  logic [tbe_pkg::RateW-1:0]       quo;
  logic [tbe_pkg::DivCountW-1:0]   div_count;

  logic signed [tbe_pkg::StampW:0] gap, max_s;
  logic [tbe_pkg::SumW-1:0]        tick_add, byte_add;
  logic                            moved, recompute_next;
  logic [tbe_pkg::SumW:0]          trial, trial_diff;
  logic                            trial_ge;
  logic [tbe_pkg::RateW-1:0]       rate_new, rate_step;

  assign gap      = $signed({1'b0, stamp_q}) - $signed({1'b0, last_stamp});
  assign max_s    = $signed({{(tbe_pkg::StampW + 1 - tbe_pkg::MaxGapW){1'b0}}, max_gap_ticks});
  assign tick_add = tick_sum + gap[tbe_pkg::SumW-1:0];
  assign byte_add = byte_sum + pending_bytes;

  always_comb begin
    last_stamp_next    = last_stamp;
    pending_bytes_next = pending_bytes;
    tick_sum_next      = tick_sum;
    byte_sum_next      = byte_sum;
    window_left_next   = window_left;
    reported_rate_next = reported_rate;
    recompute_next     = 1'b0;
    moved              = 1'b0;
    case (tbe_pkg::command_t'(command_q))
      tbe_pkg::CMD_RESET: begin
        last_stamp_next    = '0;
        pending_bytes_next = '0;
        tick_sum_next      = tbe_pkg::SumW'(1);
        byte_sum_next      = '0;
        window_left_next   = {1'b0, window_length};
        reported_rate_next = '0;
      end
      tbe_pkg::CMD_DISCONT: begin
        last_stamp_next    = '0;
        pending_bytes_next = '0;
      end
      tbe_pkg::CMD_SAMPLE: begin
        if (stamp_q != '0) begin
          if (gap > 0) begin
            if (gap < max_s) begin
              moved         = 1'b1;
              tick_sum_next = tick_add;
              byte_sum_next = byte_add;
              if (window_left == '0) begin
                window_left_next = {1'b0, window_length};
                recompute_next   = 1'b1;
                if (tick_add[tbe_pkg::SumW-1] || byte_add[tbe_pkg::SumW-1]) begin
                  tick_sum_next = tick_add >> 1;
                  byte_sum_next = byte_add >> 1;
                end
              end else begin
                window_left_next = window_left - 1'b1;
              end
            end
            last_stamp_next = stamp_q;
          end else if (gap <= -max_s) begin
            last_stamp_next = stamp_q;
          end
        end
        pending_bytes_next = (moved ? '0 : pending_bytes) + tbe_pkg::SumW'(bytes_q);
      end
      default: ;
    endcase
  end

  assign trial      = {rem, dividend_lo[tbe_pkg::RateW-1]};
  assign trial_diff = trial - {1'b0, divisor_q};
  assign trial_ge   = (trial >= {1'b0, divisor_q});

  assign rate_new  = sat_q ? tbe_pkg::RateMax : quo;
  assign rate_step = (rate_new >= reported_rate) ? rate_new - reported_rate
                                                 : reported_rate - rate_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= tbe_pkg::WindowLenReset;
      max_gap_ticks <= tbe_pkg::MaxGapReset;
      last_stamp    <= '0;
      pending_bytes <= '0;
      tick_sum      <= tbe_pkg::SumW'(1);
      byte_sum      <= '0;
      window_left   <= {1'b0, tbe_pkg::WindowLenReset};
      reported_rate <= '0;
      changed       <= 1'b0;
      div_count     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (tbe_pkg::reg_index_t'(cfg_index))
          tbe_pkg::REG_WINDOW_LENGTH: window_length <= cfg_data[tbe_pkg::WindowW-1:0];
          tbe_pkg::REG_MAX_GAP:       max_gap_ticks <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.step) begin
        last_stamp    <= last_stamp_next;
        pending_bytes <= pending_bytes_next;
        tick_sum      <= tick_sum_next;
        byte_sum      <= byte_sum_next;
        window_left   <= window_left_next;
        reported_rate <= reported_rate_next;
        changed       <= 1'b0;
      end
      if (cmd.div_init) begin
        div_count <= '0;
      end else if (cmd.div_step) begin
        div_count <= div_count + 1'b1;
      end
      if (cmd.compare && (rate_step > (rate_new >> tbe_pkg::HysteresisShift))) begin
        reported_rate <= rate_new;
        changed       <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      command_q <= in_command;
      stamp_q   <= in_stamp;
      bytes_q   <= in_byte_count;
    end
    if (cmd.mul) begin
      product   <= {{tbe_pkg::ScaleW{1'b0}}, byte_sum}
                 * {{tbe_pkg::SumW{1'b0}}, tbe_pkg::RateScale};
      divisor_q <= (tick_sum == '0) ? tbe_pkg::SumW'(1) : tick_sum;
    end
    if (cmd.div_init) begin
      sat_q       <= {{(tbe_pkg::SumW + tbe_pkg::RateW - tbe_pkg::ProductW){1'b0}}, product}
                  >= {divisor_q, {tbe_pkg::RateW{1'b0}}};
      rem         <= {{(tbe_pkg::SumW - (tbe_pkg::ProductW - tbe_pkg::RateW)){1'b0}},
                      product[tbe_pkg::ProductW-1:tbe_pkg::RateW]};
      dividend_lo <= product[tbe_pkg::RateW-1:0];
      quo         <= '0;
    end else if (cmd.div_step) begin
      rem         <= trial_ge ? trial_diff[tbe_pkg::SumW-1:0] : trial[tbe_pkg::SumW-1:0];
      quo         <= {quo[tbe_pkg::RateW-2:0], trial_ge};
      dividend_lo <= dividend_lo << 1;
    end
    if (cmd.emit) begin
      out_rate         <= reported_rate;
      out_rate_changed <= changed;
    end
  end

  assign stat.recompute = recompute_next;
  assign stat.div_done  = (div_count == tbe_pkg::DivCountW'(tbe_pkg::DivSteps - 1));
  assign stat.out_free  = !out_valid || out_ready;

  `ASSERT_IMPLIES(a_rem_below_div, clk, rst, cmd.div_step && !sat_q, rem < divisor_q)
  `ASSERT_NEXT(a_emit_valid, clk, rst, cmd.emit, out_valid)

endmodule

// ===== sv/timestamp_bitrate_estimator_top.sv =====
// Top level of the timestamp bitrate estimator.
// Depends on tbe_pkg, tbe_ifs (channel interfaces), tbe_ctrl and tbe_dp.

// One result per sample item. An item whose gap closes a window passes, from
// acceptance until the next item can be taken, through capture, state update,
// the product, a range check, the bit-serial restoring divider, the hysteresis
// compare and the output load. Every other item passes through capture, state
// update and the output load only. A finished result waits in the output
// register while the next item is accepted. Register writes are taken in any
// cycle and must only be issued while the block is idle.
module timestamp_bitrate_estimator_top (
  input  logic         clk,
  input  logic         rst,
  tbe_sample_if.sink   sample,
  tbe_result_if.source result,
  tbe_cfg_if.sink      cfg
);

  tbe_pkg::cmd_t  cmd;
  tbe_pkg::stat_t stat;

  assign cfg.ready = 1'b1;

  tbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tbe_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .in_command       (sample.command),
    .in_stamp         (sample.stamp),
    .in_byte_count    (sample.byte_count),
    .cfg_valid        (cfg.valid),
    .cfg_index        (cfg.index),
    .cfg_data         (cfg.data),
    .out_ready        (result.ready),
    .out_valid        (result.valid),
    .out_rate         (result.rate),
    .out_rate_changed (result.rate_changed)
  );

endmodule

// ===== tb/tbe_checker.sv =====
// Checker for the timestamp bitrate estimator: follows register writes and sample
// transactions, predicts each result and compares it with the result channel.
// Depends on tbe_pkg and the channel interfaces of tbe_ifs.
module tbe_checker
  import tbe_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  tbe_sample_if sample,
  tbe_result_if result,
  tbe_cfg_if    cfg,
  output int    errors,
  output int    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [WindowW-1:0] DefaultWindow = 8'd20;
  localparam logic [MaxGapW-1:0] DefaultMaxGap = 24'd220000;
  localparam logic [63:0]        BitsPerTickScale = 64'd720000;  // 90 kHz * 8 bits
  localparam logic [31:0]        RateCeiling = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [RateW-1:0] rate;
    logic             changed;
  } rate_report_t;

  rate_report_t rate_reports[$];

  logic [WindowW-1:0]     window_len;
  logic [MaxGapW-1:0]     max_gap;
  logic [StampW-1:0]      last_stamp;
  logic [SumW-1:0]        pending_bytes;
  logic [SumW-1:0]        tick_sum;
  logic [SumW-1:0]        byte_sum;
  logic [WindowLeftW-1:0] window_left;
  logic [RateW-1:0]       reported_rate;

  function automatic void clear_estimate();
    last_stamp    = '0;
    pending_bytes = '0;
    tick_sum      = 32'd1;
    byte_sum      = '0;
    window_left   = WindowLeftW'(window_len);
    reported_rate = '0;
  endfunction

  function automatic logic recompute_rate();
    logic [63:0] divisor;
    logic [63:0] quotient;
    logic [31:0] new_rate;
    logic [31:0] step;
    if (byte_sum[SumW-1] || tick_sum[SumW-1]) begin
      byte_sum = byte_sum >> 1;
      tick_sum = tick_sum >> 1;
    end
    divisor  = (tick_sum != '0) ? 64'(tick_sum) : 64'd1;
    quotient = (64'(byte_sum) * BitsPerTickScale) / divisor;
    new_rate = (quotient > 64'(RateCeiling)) ? RateCeiling : quotient[31:0];
    step = (new_rate >= 32'(reported_rate)) ? new_rate - 32'(reported_rate)
                                            : 32'(reported_rate) - new_rate;
    if (step > (new_rate >> 6)) begin
      reported_rate = new_rate[RateW-1:0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic rate_report_t apply_sample(input logic [CommandW-1:0] command,
                                                input logic [StampW-1:0]   stamp,
                                                input logic [BytesW-1:0]   nbytes);
    logic         changed;
    logic [StampW-1:0] gap;
    rate_report_t report;
    changed = 1'b0;
    case (command)
      CMD_RESET: begin
        clear_estimate();
      end
      CMD_DISCONT: begin
        last_stamp    = '0;
        pending_bytes = '0;
      end
      CMD_SAMPLE: begin
        if (stamp != '0) begin
          if (stamp > last_stamp) begin
            gap = stamp - last_stamp;
            if (gap < max_gap) begin
              tick_sum      = tick_sum + gap[SumW-1:0];
              byte_sum      = byte_sum + pending_bytes;
              pending_bytes = '0;
              if (window_left == '0) begin
                window_left = WindowLeftW'(window_len);
                changed     = recompute_rate();
              end else begin
                window_left = window_left - 1'b1;
              end
            end
            last_stamp = stamp;
          end else if (last_stamp - stamp >= max_gap) begin
            last_stamp = stamp;
          end
        end
        pending_bytes = pending_bytes + 32'(nbytes);
      end
      default: ;
    endcase
    report.rate    = reported_rate;
    report.changed = changed;
    return report;
  endfunction

  always @(posedge clk) begin
    rate_report_t want;
    if (rst) begin
      window_len = DefaultWindow;
      max_gap    = DefaultMaxGap;
      clear_estimate();
      rate_reports.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_WINDOW_LENGTH) begin
          window_len = cfg.data[WindowW-1:0];
        end else begin
          max_gap = cfg.data[MaxGapW-1:0];
        end
      end
      if (sample.valid && sample.ready) begin
        rate_reports.push_back(apply_sample(sample.command, sample.stamp, sample.byte_count));
      end
      if (result.valid && result.ready) begin
        if (rate_reports.size() == 0) begin
          $error("result transaction with no sample pending: rate %0d", result.rate);
          errors++;
        end else begin
          want = rate_reports.pop_front();
          if (result.rate !== want.rate) begin
            $error("rate: expected %0d, actual %0d", want.rate, result.rate);
            errors++;
          end
          if (result.rate_changed !== want.changed) begin
            $error("rate_changed: expected %0b, actual %0b", want.changed,
                   result.rate_changed);
            errors++;
          end
        end
      end
    end
    outstanding <= rate_reports.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top of the timestamp bitrate estimator: clock, reset, register writes,
// directed and random sample transactions, result back-pressure and the verdict.
// Depends on tbe_pkg, tbe_ifs, the estimator RTL and tbe_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tbe_pkg::*;

  localparam logic [CommandW-1:0] CmdReserved   = 2'd3;
  localparam logic [StampW-1:0]   StampAllOnes  = '1;
  localparam logic [BytesW-1:0]   BytesAllOnes  = '1;
  localparam logic [MaxGapW-1:0]  MaxGapAllOnes = '1;
  localparam logic [WindowW-1:0]  WindowAllOnes = '1;
  localparam int                  PhaseItems    = 100;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic               clk;
  logic               rst;
  int                 fail_count;
  int                 reports_pending;
  int                 sender_idle_pct;
  int                 stall_pct;
  logic [StampW-1:0]  stream_stamp;
  logic [MaxGapW-1:0] gap_limit;

  tbe_sample_if sample_ch ();
  tbe_result_if result_ch ();
  tbe_cfg_if    cfg_ch ();

  timestamp_bitrate_estimator_top DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  tbe_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample_ch),
    .result      (result_ch),
    .cfg         (cfg_ch),
    .errors      (fail_count),
    .outstanding (reports_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("** timestamp_bitrate_estimator_top: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [StampW-1:0] random_stamp();
    return {1'($urandom()), 32'($urandom())};
  endfunction

  function automatic logic [MaxGapW-1:0] largest_gap();
    return (gap_limit > 24'd1) ? gap_limit - 24'd1 : 24'd1;
  endfunction

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        sender_idle_pct = 70;
        stall_pct       = 0;
      end
      IDLE_RECEIVER: begin
        sender_idle_pct = 0;
        stall_pct       = 70;
      end
      IDLE_BOTH: begin
        sender_idle_pct = 38;
        stall_pct       = 38;
      end
      default: begin
        sender_idle_pct = 0;
        stall_pct       = 0;
      end
    endcase
  endtask

  task automatic send_item(input logic [CommandW-1:0] command,
                           input logic [StampW-1:0]   stamp,
                           input logic [BytesW-1:0]   nbytes);
    while ($urandom_range(99) < sender_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid      <= 1'b1;
    sample_ch.command    <= command;
    sample_ch.stamp      <= stamp;
    sample_ch.byte_count <= nbytes;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  // Hold the sample channel until every result has been taken.
  task automatic drain();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (reports_pending != 0);
  endtask

  task automatic write_registers(input logic [WindowW-1:0] window,
                                 input logic [MaxGapW-1:0] max_gap);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_WINDOW_LENGTH;
    cfg_ch.data  <= {16'($urandom()), window};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= REG_MAX_GAP;
    cfg_ch.data  <= max_gap;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    gap_limit = max_gap;
  endtask

  task automatic send_random_item(input logic [MaxGapW-1:0] base_gap,
                                  input logic [BytesW-1:0]  base_bytes);
    int unsigned        roll;
    logic [MaxGapW-1:0] gap;
    logic [BytesW-1:0]  nbytes;
    roll   = $urandom_range(99);
    nbytes = ($urandom_range(7) == 0) ? BytesW'($urandom())
                                      : base_bytes + BytesW'($urandom_range(0, 255));
    if (roll < 70) begin
      gap = base_gap + MaxGapW'($urandom_range(0, base_gap / 16));
      if (gap > largest_gap()) gap = largest_gap();
      stream_stamp = stream_stamp + StampW'(gap);
      send_item(CMD_SAMPLE, stream_stamp, nbytes);
    end else if (roll < 76) begin
      send_item(CMD_SAMPLE, '0, nbytes);
    end else if (roll < 80) begin
      send_item(CMD_SAMPLE, stream_stamp, nbytes);
    end else if (roll < 84) begin
      send_item(CMD_SAMPLE, stream_stamp - StampW'($urandom_range(1, largest_gap())), nbytes);
    end else if (roll < 88) begin
      stream_stamp = stream_stamp + StampW'(gap_limit) + StampW'($urandom_range(0, 1000000));
      send_item(CMD_SAMPLE, stream_stamp, nbytes);
    end else if (roll < 91) begin
      stream_stamp = stream_stamp - StampW'(gap_limit) - StampW'($urandom_range(0, 1000000));
      send_item(CMD_SAMPLE, stream_stamp, nbytes);
    end else if (roll < 94) begin
      stream_stamp = random_stamp();
      send_item(CMD_SAMPLE, stream_stamp, nbytes);
    end else if (roll < 96) begin
      send_item(CMD_DISCONT, random_stamp(), BytesW'($urandom()));
    end else if (roll < 98) begin
      send_item(CMD_RESET, random_stamp(), BytesW'($urandom()));
    end else begin
      send_item(CmdReserved, random_stamp(), BytesW'($urandom()));
    end
  endtask

  initial begin
    logic [MaxGapW-1:0] base_gap;
    logic [BytesW-1:0]  base_bytes;
    logic [MaxGapW-1:0] short_cap;
    rst                  = 1'b1;
    sample_ch.valid      = 1'b0;
    sample_ch.command    = CMD_SAMPLE;
    sample_ch.stamp      = '0;
    sample_ch.byte_count = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_WINDOW_LENGTH;
    cfg_ch.data          = '0;
    stream_stamp         = '0;
    gap_limit            = 24'd220000;
    set_idling(IDLE_NONE);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: stamp handling at the power-on register values
    send_item(CMD_SAMPLE, '0, '0);
    send_item(CMD_SAMPLE, '0, BytesAllOnes);
    send_item(CMD_SAMPLE, 33'd1000, 16'd1200);
    send_item(CMD_SAMPLE, 33'd1000, 16'd100);
    send_item(CMD_SAMPLE, 33'd900, 16'd100);
    send_item(CMD_SAMPLE, 33'd221000, 16'd100);
    send_item(CMD_SAMPLE, 33'd440999, 16'd100);
    send_item(CMD_SAMPLE, StampAllOnes, BytesAllOnes);
    send_item(CMD_SAMPLE, 33'd5, 16'd100);
    send_item(CMD_DISCONT, StampAllOnes, BytesAllOnes);
    send_item(CmdReserved, StampAllOnes, BytesAllOnes);
    send_item(CMD_RESET, StampAllOnes, BytesAllOnes);

    // directed: recompute on every gap, saturation, hold and drop
    drain();
    write_registers('0, MaxGapAllOnes);
    send_item(CMD_RESET, '0, '0);
    send_item(CMD_SAMPLE, 33'd10, BytesAllOnes);
    send_item(CMD_SAMPLE, 33'd11, BytesAllOnes);
    send_item(CMD_SAMPLE, 33'd12, '0);
    send_item(CMD_SAMPLE, 33'd12 + 33'd16777214, '0);
    send_item(CMD_SAMPLE, 33'd13 + 33'd16777214, 16'd7);

    // longest window: tick sum halves after the first, wraps to zero after the second
    drain();
    write_registers(WindowAllOnes, MaxGapAllOnes);
    set_idling(IDLE_RECEIVER);
    send_item(CMD_RESET, '0, '0);
    stream_stamp = '0;
    for (int i = 0; i < 256; i++) begin
      stream_stamp = stream_stamp + 33'd8388608;
      send_item(CMD_SAMPLE, stream_stamp, 16'd1000);
    end
    for (int i = 0; i < 256; i++) begin
      stream_stamp = stream_stamp + 33'd12582912;
      send_item(CMD_SAMPLE, stream_stamp, 16'd1000);
    end

    for (int p = 0; p < 10; p++) begin
      drain();
      case (p)
        0: write_registers(8'd20, 24'd220000);
        1: write_registers('0, 24'd1);
        2: write_registers(WindowAllOnes, MaxGapAllOnes);
        3: write_registers(8'd3, 24'd4000);
        4: write_registers(8'd1, 24'd60000);
        5: write_registers('0, MaxGapAllOnes);
        6: write_registers(8'd7, 24'd220000);
        8: write_registers(8'd2, 24'd1000);
        default: write_registers(8'($urandom_range(0, 15)),
                                 24'($urandom_range(1, 24'hFFFFFF)));
      endcase
      set_idling(idle_mode_t'(p % 4));
      for (int i = 0; i < PhaseItems; i++) begin
        if (i % 25 == 0) begin
          short_cap  = (largest_gap() < 24'd4000) ? largest_gap() : 24'd4000;
          base_gap   = ($urandom_range(3) == 0) ? 24'($urandom_range(1, largest_gap()))
                                                : 24'($urandom_range(1, short_cap));
          base_bytes = BytesW'($urandom());
        end
        if (i == PhaseItems / 2) drain();
        send_random_item(base_gap, base_bytes);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("** timestamp_bitrate_estimator_top: PASSED **");
    end else begin
      $display("** timestamp_bitrate_estimator_top: FAILED **");
    end
    $finish;
  end

endmodule
